FILE: rtl/wpa_pkg.sv
// ----------------------------------------------------------------------------
// wpa_pkg
// Shared types, constants and helpers of the wall push-out accumulator.
// ----------------------------------------------------------------------------
package wpa_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_W         = 31;
  localparam int CRD_W         = 32;
  localparam int HIT_W         = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CNT_W         = 6;
  localparam int RT_STEPS      = 32;
  localparam int WW            = 35;   // bound / offset arithmetic
  localparam int DPW           = 36;   // signed penetration depth
  localparam int PW            = 64;   // product / root operand

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_LONG  = 2'd0,
    REG_HALF_SHORT = 2'd1,
    REG_RADIUS     = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    SRC_D = 2'd0,
    SRC_V = 2'd1,
    SRC_E = 2'd2
  } src_t;

  typedef enum logic [4:0] {
    OP_NONE     = 5'd0,
    OP_LOAD     = 5'd1,
    OP_BOUND    = 5'd2,
    OP_SQ_A     = 5'd3,
    OP_SQ_B     = 5'd4,
    OP_SQ_R     = 5'd5,
    OP_VEC      = 5'd6,
    OP_RT_INIT  = 5'd7,
    OP_RT_STEP  = 5'd8,
    OP_DIV_INIT = 5'd9,
    OP_DIV_STEP = 5'd10,
    OP_DIV_DONE = 5'd11,
    OP_DEPTH    = 5'd12,
    OP_MUL      = 5'd13,
    OP_CLAMP    = 5'd14,
    OP_ADD      = 5'd15,
    OP_EMIT     = 5'd16
  } op_t;

  typedef struct packed {
    op_t  op;
    src_t src;
    logic zsel;
  } dp_cmd_t;

  typedef struct packed {
    logic is_wall;
    logic last;
    logic box_fail;
    logic circ_fail;
  } dp_stat_t;

  function automatic logic signed [WW-1:0] clampw(input logic signed [WW-1:0] v,
                                                  input logic signed [WW-1:0] lo,
                                                  input logic signed [WW-1:0] hi);
    logic signed [WW-1:0] r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [WW-1:0] absw(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] r;
    r = v[WW-1] ? -v : v;
    return r;
  endfunction

endpackage

FILE: rtl/wall_pushout_accumulator.sv
// Work: an object that is not a wall, or a wall that misses, skips the roots and divides;
//   a wall that hits runs two 32-step square roots and two FRAC_BITS+1 step divides.
// Throughput: one object at a time; the frame result leaves through an output
//   register, and a last object waits only if the previous result is still held.
// Reset: synchronous active-low; clears config, previous position, sums and count.
// ----------------------------------------------------------------------------
// wall_pushout_accumulator
// Per-frame sum of circle-versus-wall push-out vectors, Q16.16 by default.
// ----------------------------------------------------------------------------
module wall_pushout_accumulator #(
  parameter int FRAC_BITS = wpa_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [wpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [wpa_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_is_wall,
  input  logic                              in_rotated,
  input  logic signed [wpa_pkg::CRD_W-1:0]  in_wall_x,
  input  logic signed [wpa_pkg::CRD_W-1:0]  in_wall_z,
  input  logic signed [wpa_pkg::CRD_W-1:0]  in_player_x,
  input  logic signed [wpa_pkg::CRD_W-1:0]  in_player_z,
  input  logic                              in_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [wpa_pkg::CRD_W-1:0]  out_push_x,
  output logic signed [wpa_pkg::CRD_W-1:0]  out_push_z,
  output logic [wpa_pkg::HIT_W-1:0]         out_hit_count
);
  import wpa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  wpa_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  wpa_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_is_wall    (in_is_wall),
    .in_rotated    (in_rotated),
    .in_wall_x     (in_wall_x),
    .in_wall_z     (in_wall_z),
    .in_player_x   (in_player_x),
    .in_player_z   (in_player_z),
    .in_last       (in_last),
    .cmd           (cmd),
    .stat          (stat),
    .out_push_x    (out_push_x),
    .out_push_z    (out_push_z),
    .out_hit_count (out_hit_count)
  );

endmodule

FILE: rtl/wpa_ctrl.sv
// ----------------------------------------------------------------------------
// wpa_ctrl
// Sequencer: walks the datapath through bounds, hit test, roots, divides
// and accumulation, and owns the input and result handshakes.
// ----------------------------------------------------------------------------
module wpa_ctrl #(
  parameter int FRAC_BITS = wpa_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  wpa_pkg::dp_stat_t stat,
  output wpa_pkg::dp_cmd_t  cmd
);
  import wpa_pkg::*;

  typedef enum logic [29:0] {
    ST_IDLE    = 30'd1 << 0,
    ST_BOUND   = 30'd1 << 1,
    ST_TEST    = 30'd1 << 2,
    ST_DSQ_A   = 30'd1 << 3,
    ST_DSQ_B   = 30'd1 << 4,
    ST_DSQ_R   = 30'd1 << 5,
    ST_DCHK    = 30'd1 << 6,
    ST_VEC     = 30'd1 << 7,
    ST_VSQ_A   = 30'd1 << 8,
    ST_VSQ_B   = 30'd1 << 9,
    ST_VRT_I   = 30'd1 << 10,
    ST_VRT     = 30'd1 << 11,
    ST_XDIV_I  = 30'd1 << 12,
    ST_XDIV    = 30'd1 << 13,
    ST_XDIV_F  = 30'd1 << 14,
    ST_ZDIV_I  = 30'd1 << 15,
    ST_ZDIV    = 30'd1 << 16,
    ST_ZDIV_F  = 30'd1 << 17,
    ST_ESQ_A   = 30'd1 << 18,
    ST_ESQ_B   = 30'd1 << 19,
    ST_ERT_I   = 30'd1 << 20,
    ST_ERT     = 30'd1 << 21,
    ST_DEPTH   = 30'd1 << 22,
    ST_XMUL    = 30'd1 << 23,
    ST_XCLP    = 30'd1 << 24,
    ST_XADD    = 30'd1 << 25,
    ST_ZMUL    = 30'd1 << 26,
    ST_ZCLP    = 30'd1 << 27,
    ST_ZADD    = 30'd1 << 28,
    ST_FIN     = 30'd1 << 29
  } state_t;

  localparam logic [CNT_W-1:0] RT_LAST  = CNT_W'(RT_STEPS - 1);
  localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(FRAC_BITS);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.src       = SRC_D;
    cmd.zsel      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = ST_BOUND;
        end
      end
      ST_BOUND: begin
        cmd.op    = OP_BOUND;
        state_nxt = ST_TEST;
      end
      ST_TEST: begin
        state_nxt = (!stat.is_wall || stat.box_fail) ? ST_FIN : ST_DSQ_A;
      end
      ST_DSQ_A: begin
        cmd.op    = OP_SQ_A;
        state_nxt = ST_DSQ_B;
      end
      ST_DSQ_B: begin
        cmd.op    = OP_SQ_B;
        state_nxt = ST_DSQ_R;
      end
      ST_DSQ_R: begin
        cmd.op    = OP_SQ_R;
        state_nxt = ST_DCHK;
      end
      ST_DCHK: begin
        state_nxt = stat.circ_fail ? ST_FIN : ST_VEC;
      end
      ST_VEC: begin
        cmd.op    = OP_VEC;
        state_nxt = ST_VSQ_A;
      end
      ST_VSQ_A: begin
        cmd.op    = OP_SQ_A;
        cmd.src   = SRC_V;
        state_nxt = ST_VSQ_B;
      end
      ST_VSQ_B: begin
        cmd.op    = OP_SQ_B;
        cmd.src   = SRC_V;
        state_nxt = ST_VRT_I;
      end
      ST_VRT_I: begin
        cmd.op    = OP_RT_INIT;
        state_nxt = ST_VRT;
      end
      ST_VRT: begin
        cmd.op  = OP_RT_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == RT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_XDIV_I;
        end
      end
      ST_XDIV_I: begin
        cmd.op    = OP_DIV_INIT;
        state_nxt = ST_XDIV;
      end
      ST_XDIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_XDIV_F;
        end
      end
      ST_XDIV_F: begin
        cmd.op    = OP_DIV_DONE;
        state_nxt = ST_ZDIV_I;
      end
      ST_ZDIV_I: begin
        cmd.op    = OP_DIV_INIT;
        cmd.zsel  = 1'b1;
        state_nxt = ST_ZDIV;
      end
      ST_ZDIV: begin
        cmd.op  = OP_DIV_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == DIV_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_ZDIV_F;
        end
      end
      ST_ZDIV_F: begin
        cmd.op    = OP_DIV_DONE;
        cmd.zsel  = 1'b1;
        state_nxt = ST_ESQ_A;
      end
      ST_ESQ_A: begin
        cmd.op    = OP_SQ_A;
        cmd.src   = SRC_E;
        state_nxt = ST_ESQ_B;
      end
      ST_ESQ_B: begin
        cmd.op    = OP_SQ_B;
        cmd.src   = SRC_E;
        state_nxt = ST_ERT_I;
      end
      ST_ERT_I: begin
        cmd.op    = OP_RT_INIT;
        state_nxt = ST_ERT;
      end
      ST_ERT: begin
        cmd.op  = OP_RT_STEP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == RT_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_DEPTH;
        end
      end
      ST_DEPTH: begin
        cmd.op    = OP_DEPTH;
        state_nxt = ST_XMUL;
      end
      ST_XMUL: begin
        cmd.op    = OP_MUL;
        state_nxt = ST_XCLP;
      end
      ST_XCLP: begin
        cmd.op    = OP_CLAMP;
        state_nxt = ST_XADD;
      end
      ST_XADD: begin
        cmd.op    = OP_ADD;
        state_nxt = ST_ZMUL;
      end
      ST_ZMUL: begin
        cmd.op    = OP_MUL;
        cmd.zsel  = 1'b1;
        state_nxt = ST_ZCLP;
      end
      ST_ZCLP: begin
        cmd.op    = OP_CLAMP;
        cmd.zsel  = 1'b1;
        state_nxt = ST_ZADD;
      end
      ST_ZADD: begin
        cmd.op    = OP_ADD;
        cmd.zsel  = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!stat.last) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || out_ready) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: rtl/wpa_dp.sv
// ----------------------------------------------------------------------------
// wpa_dp
// Datapath: config and frame state, bound clamps, one squaring multiplier and one product
// multiplier, a bit-pair square root, a restoring divider and the saturating sums.
// ----------------------------------------------------------------------------
module wpa_dp #(
  parameter int FRAC_BITS = wpa_pkg::FRAC_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [wpa_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [wpa_pkg::CFG_W-1:0]            cfg_wdata,
  input  logic                                 in_is_wall,
  input  logic                                 in_rotated,
  input  logic signed [wpa_pkg::CRD_W-1:0]     in_wall_x,
  input  logic signed [wpa_pkg::CRD_W-1:0]     in_wall_z,
  input  logic signed [wpa_pkg::CRD_W-1:0]     in_player_x,
  input  logic signed [wpa_pkg::CRD_W-1:0]     in_player_z,
  input  logic                                 in_last,
  input  wpa_pkg::dp_cmd_t                     cmd,
  output wpa_pkg::dp_stat_t                    stat,
  output logic signed [wpa_pkg::CRD_W-1:0]     out_push_x,
  output logic signed [wpa_pkg::CRD_W-1:0]     out_push_z,
  output logic [wpa_pkg::HIT_W-1:0]            out_hit_count
);
  import wpa_pkg::*;

  localparam int UW = FRAC_BITS + 1;
  localparam int QW = FRAC_BITS + 2;
  localparam int LW = CRD_W + 2;
  localparam logic signed [PW-1:0] S32_MAX = PW'(64'sh0000_0000_7fff_ffff);
  localparam logic signed [PW-1:0] S32_MIN = -PW'(64'sh0000_0000_8000_0000);

  logic [CFG_W-1:0]        hl_r, hs_r, rad_r;
  logic signed [CRD_W-1:0] prev_x_r, prev_z_r, sum_x_r, sum_z_r;
  logic [HIT_W-1:0]        hits_r;

  logic                    is_wall_r, last_r, rot_r;
  logic signed [CRD_W-1:0] wx_r, wz_r, px_r, pz_r;
  logic signed [WW-1:0]    dx_r, dz_r, cx_r, cz_r;
  logic signed [CRD_W-1:0] va_r, vb_r, ea_r, eb_r;
  logic                    e_big_r;
  logic [PW-1:0]           prod_r, acc_r;
  logic [PW-1:0]           rt_n_r, rt_res_r, rt_bit_r;
  logic [CRD_W-1:0]        dv_n_r;
  logic [CRD_W:0]          dv_rem_r;
  logic [UW-1:0]           dv_q_r;
  logic signed [QW-1:0]    ux_r, uz_r;
  logic signed [DPW-1:0]   depth_r;
  logic                    pneg_r;
  logic signed [CRD_W-1:0] q_r;
  logic signed [CRD_W-1:0] push_x_r, push_z_r;
  logic [HIT_W-1:0]        hit_cnt_r;

  logic [CFG_W-1:0]        hx, hz;
  logic signed [WW-1:0]    hxw, hzw, wxw, wzw, pxw, pzw, pvxw, pvzw, rw;
  logic signed [WW-1:0]    lox, hix, loz, hiz, dx_nxt, dz_nxt, cx_nxt, cz_nxt;
  logic signed [WW-1:0]    vx, vz, ex, ez, vxa, vza, exa, eza;
  logic                    v_big, e_big;
  logic signed [WW-1:0]    vxs, vzs, exs, ezs;
  logic [CRD_W-1:0]        a_mag, b_mag, va_mag, vb_mag, sq_op;
  logic [PW-1:0]           sq_prod, rt_t, mul_prod;
  logic                    rt_ge, dv_ge;
  logic [CRD_W:0]          dv_sub;
  logic [CRD_W-1:0]        rem_after;
  logic signed [QW-1:0]    uq, u_val, u_sel, u_abs;
  logic [LW-1:0]           len;
  logic signed [DPW-1:0]   dep_nxt, dep_abs;
  logic [PW-1:0]           mag;
  logic signed [PW-1:0]    qv;
  logic signed [CRD_W-1:0] q_nxt, sum_sel;
  logic signed [CRD_W:0]   sum_ext;
  logic signed [CRD_W-1:0] sum_sat;

  always_comb begin
    hx   = rot_r ? hl_r : hs_r;
    hz   = rot_r ? hs_r : hl_r;
    hxw  = $signed({{(WW-CFG_W){1'b0}}, hx});
    hzw  = $signed({{(WW-CFG_W){1'b0}}, hz});
    rw   = $signed({{(WW-CFG_W){1'b0}}, rad_r});
    wxw  = WW'(wx_r);
    wzw  = WW'(wz_r);
    pxw  = WW'(px_r);
    pzw  = WW'(pz_r);
    pvxw = WW'(prev_x_r);
    pvzw = WW'(prev_z_r);
    lox  = wxw - hxw;
    hix  = wxw + hxw;
    loz  = wzw - hzw;
    hiz  = wzw + hzw;
    dx_nxt = pxw - clampw(pxw, lox, hix);
    dz_nxt = pzw - clampw(pzw, loz, hiz);
    cx_nxt = clampw(pvxw, lox, hix);
    cz_nxt = clampw(pvzw, loz, hiz);

    vx  = pvxw - cx_r;
    vz  = pvzw - cz_r;
    ex  = pxw - cx_r;
    ez  = pzw - cz_r;
    vxa = absw(vx);
    vza = absw(vz);
    exa = absw(ex);
    eza = absw(ez);
    v_big = (|vxa[WW-1:CRD_W-1]) || (|vza[WW-1:CRD_W-1]);
    e_big = (|exa[WW-1:CRD_W-1]) || (|eza[WW-1:CRD_W-1]);
    vxs = v_big ? (vx >>> 2) : vx;
    vzs = v_big ? (vz >>> 2) : vz;
    exs = e_big ? (ex >>> 2) : ex;
    ezs = e_big ? (ez >>> 2) : ez;

    va_mag = va_r[CRD_W-1] ? CRD_W'(-va_r) : CRD_W'(va_r);
    vb_mag = vb_r[CRD_W-1] ? CRD_W'(-vb_r) : CRD_W'(vb_r);
    case (cmd.src)
      SRC_D: begin
        a_mag = CRD_W'(absw(dx_r));
        b_mag = CRD_W'(absw(dz_r));
      end
      SRC_V: begin
        a_mag = va_mag;
        b_mag = vb_mag;
      end
      SRC_E: begin
        a_mag = ea_r[CRD_W-1] ? CRD_W'(-ea_r) : CRD_W'(ea_r);
        b_mag = eb_r[CRD_W-1] ? CRD_W'(-eb_r) : CRD_W'(eb_r);
      end
      default: begin
        a_mag = '0;
        b_mag = '0;
      end
    endcase
    case (cmd.op)
      OP_SQ_B: sq_op = b_mag;
      OP_SQ_R: sq_op = {1'b0, rad_r};
      default: sq_op = a_mag;
    endcase
    sq_prod = PW'(sq_op) * PW'(sq_op);

    rt_t  = rt_res_r + rt_bit_r;
    rt_ge = rt_n_r >= rt_t;

    dv_ge     = dv_rem_r >= {1'b0, dv_n_r};
    dv_sub    = dv_rem_r - {1'b0, dv_n_r};
    rem_after = dv_ge ? dv_sub[CRD_W-1:0] : dv_rem_r[CRD_W-1:0];
    uq        = $signed({1'b0, dv_q_r});
    if (dv_n_r == '0) begin
      u_val = '0;
    end else if (cmd.zsel ? vb_r[CRD_W-1] : va_r[CRD_W-1]) begin
      u_val = -uq;
    end else begin
      u_val = uq;
    end

    len     = {2'b00, rt_res_r[CRD_W-1:0]} << (e_big_r ? 2 : 0);
    dep_nxt = $signed({{(DPW-CFG_W){1'b0}}, rad_r}) - $signed({{(DPW-LW){1'b0}}, len});

    u_sel    = cmd.zsel ? uz_r : ux_r;
    u_abs    = u_sel[QW-1] ? -u_sel : u_sel;
    dep_abs  = depth_r[DPW-1] ? -depth_r : depth_r;
    mul_prod = PW'(u_abs[UW-1:0]) * PW'(dep_abs[DPW-2:0]);

    mag = prod_r >> FRAC_BITS;
    qv  = pneg_r ? -$signed(mag) : $signed(mag);
    if (qv > S32_MAX) begin
      q_nxt = CRD_W'(S32_MAX);
    end else if (qv < S32_MIN) begin
      q_nxt = CRD_W'(S32_MIN);
    end else begin
      q_nxt = CRD_W'(qv);
    end

    sum_sel = cmd.zsel ? sum_z_r : sum_x_r;
    sum_ext = {sum_sel[CRD_W-1], sum_sel} + {q_r[CRD_W-1], q_r};
    if (sum_ext[CRD_W] != sum_ext[CRD_W-1]) begin
      sum_sat = sum_ext[CRD_W] ? {1'b1, {(CRD_W-1){1'b0}}} : {1'b0, {(CRD_W-1){1'b1}}};
    end else begin
      sum_sat = sum_ext[CRD_W-1:0];
    end
  end

  assign stat.is_wall   = is_wall_r;
  assign stat.last      = last_r;
  assign stat.box_fail  = (absw(dx_r) > rw) || (absw(dz_r) > rw);
  assign stat.circ_fail = acc_r > prod_r;

  assign out_push_x    = push_x_r;
  assign out_push_z    = push_z_r;
  assign out_hit_count = hit_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hl_r     <= '0;
      hs_r     <= '0;
      rad_r    <= '0;
      prev_x_r <= '0;
      prev_z_r <= '0;
      sum_x_r  <= '0;
      sum_z_r  <= '0;
      hits_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_HALF_LONG:  hl_r  <= cfg_wdata;
          REG_HALF_SHORT: hs_r  <= cfg_wdata;
          REG_RADIUS:     rad_r <= cfg_wdata;
          default: ;
        endcase
      end
      case (cmd.op)
        OP_ADD: begin
          if (cmd.zsel) begin
            sum_z_r <= sum_sat;
            if (hits_r != '1) begin
              hits_r <= hits_r + 1'b1;
            end
          end else begin
            sum_x_r <= sum_sat;
          end
        end
        OP_EMIT: begin
          prev_x_r <= px_r;
          prev_z_r <= pz_r;
          sum_x_r  <= '0;
          sum_z_r  <= '0;
          hits_r   <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        is_wall_r <= in_is_wall;
        last_r    <= in_last;
        rot_r     <= in_rotated;
        wx_r      <= in_wall_x;
        wz_r      <= in_wall_z;
        px_r      <= in_player_x;
        pz_r      <= in_player_z;
      end
      OP_BOUND: begin
        dx_r <= dx_nxt;
        dz_r <= dz_nxt;
        cx_r <= cx_nxt;
        cz_r <= cz_nxt;
      end
      OP_SQ_A: begin
        prod_r <= sq_prod;
      end
      OP_SQ_B: begin
        prod_r <= sq_prod;
        acc_r  <= prod_r;
      end
      OP_SQ_R: begin
        prod_r <= sq_prod;
        acc_r  <= acc_r + prod_r;
      end
      OP_VEC: begin
        va_r    <= vxs[CRD_W-1:0];
        vb_r    <= vzs[CRD_W-1:0];
        ea_r    <= exs[CRD_W-1:0];
        eb_r    <= ezs[CRD_W-1:0];
        e_big_r <= e_big;
      end
      OP_RT_INIT: begin
        rt_n_r   <= acc_r + prod_r;
        rt_res_r <= '0;
        rt_bit_r <= PW'(1) << (PW - 2);
      end
      OP_RT_STEP: begin
        if (rt_ge) begin
          rt_n_r   <= rt_n_r - rt_t;
          rt_res_r <= (rt_res_r >> 1) + rt_bit_r;
        end else begin
          rt_res_r <= rt_res_r >> 1;
        end
        rt_bit_r <= rt_bit_r >> 2;
      end
      OP_DIV_INIT: begin
        dv_n_r   <= rt_res_r[CRD_W-1:0];
        dv_rem_r <= {1'b0, (cmd.zsel ? vb_mag : va_mag)};
        dv_q_r   <= '0;
      end
      OP_DIV_STEP: begin
        dv_rem_r <= {rem_after, 1'b0};
        dv_q_r   <= {dv_q_r[UW-2:0], dv_ge};
      end
      OP_DIV_DONE: begin
        if (cmd.zsel) begin
          uz_r <= u_val;
        end else begin
          ux_r <= u_val;
        end
      end
      OP_DEPTH: begin
        depth_r <= dep_nxt;
      end
      OP_MUL: begin
        prod_r <= mul_prod;
        pneg_r <= u_sel[QW-1] ^ depth_r[DPW-1];
      end
      OP_CLAMP: begin
        q_r <= q_nxt;
      end
      OP_EMIT: begin
        push_x_r  <= sum_x_r;
        push_z_r  <= sum_z_r;
        hit_cnt_r <= hits_r;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/wpa_checker.sv
// ----------------------------------------------------------------------------
// wpa_checker
// Port-level checks of the push-out accumulator, bound to the top level.
// ----------------------------------------------------------------------------
module wpa_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [wpa_pkg::CRD_W-1:0]  out_push_x,
  input logic signed [wpa_pkg::CRD_W-1:0]  out_push_z,
  input logic [wpa_pkg::HIT_W-1:0]         out_hit_count
);

  // held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_push_x) && $stable(out_push_z))
    else $error("result beat dropped or changed while stalled");

  // one object at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous object in flight");

  // a frame without hits pushes nothing
  a_no_hit_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit_count == '0 |-> out_push_x == '0 && out_push_z == '0)
    else $error("push reported without any hit");

  // a result rises only when the sequencer is back in idle
  a_result_needs_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result raised while an object is still in work");

endmodule

bind wall_pushout_accumulator wpa_checker u_wpa_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_push_x    (out_push_x),
  .out_push_z    (out_push_z),
  .out_hit_count (out_hit_count)
);
